// File: rtl/lzs_pkg.sv
// Shared types and constants for the layer z-order stack.
package lzs_pkg;

  localparam int SLOT_W = 8;
  localparam int HGT_W  = 9;

  localparam logic signed [HGT_W-1:0] HGT_NONE = -9'sd1;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_SET   = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_PEEK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_UNUSED = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_PLAN,
    S_SHIFT,
    S_LAST,
    S_COMMIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic plan;
    logic shift;
    logic commit;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic alloc;
    logic scan_hit;
    logic scan_end;
    logic need_shift;
    logic need_commit;
    logic shift_last;
  } sts_t;

endpackage

// File: rtl/layer_z_order_stack_core.sv
// Top level of the layer z-order stack: sequencer, datapath and result register.
//
//   channel | signals                                    | direction
//   in      | in_valid in_ready kind slot requested_height | into block
//   out     | out_valid out_ready status result_slot      | out of block
//           |   result_height top_position                |
//
// Allocate scans the slots in order up to the lowest free one.
// Set height and free shift each order-list entry that has to move.
// The order-list memory port moves one entry per cycle.
// Reset clears the slot flags and the top position at once; no clearing pass.
// A finished result waits in the result register; a stalled output holds the sequencer.
module layer_z_order_stack_core #(
  parameter int LAYER_COUNT = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        kind,
  input  logic [lzs_pkg::SLOT_W-1:0]        slot,
  input  logic signed [lzs_pkg::HGT_W-1:0]  requested_height,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [lzs_pkg::SLOT_W-1:0]        result_slot,
  output logic signed [lzs_pkg::HGT_W-1:0]  result_height,
  output logic signed [lzs_pkg::HGT_W-1:0]  top_position
);
  import lzs_pkg::*;

  cmd_t                    cmd;
  sts_t                    sts;
  status_t                 res_status;
  logic [SLOT_W-1:0]       res_slot;
  logic signed [HGT_W-1:0] res_height;
  logic signed [HGT_W-1:0] top_q;
  logic                    out_free;

  assign out_free = !out_valid || out_ready;

  lzs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  lzs_dp #(
    .LAYER_COUNT (LAYER_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .kind             (kind),
    .slot             (slot),
    .requested_height (requested_height),
    .sts              (sts),
    .res_status       (res_status),
    .res_slot         (res_slot),
    .res_height       (res_height),
    .top_q            (top_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.respond) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      status        <= res_status;
      result_slot   <= res_slot;
      result_height <= res_height;
      top_position  <= top_q;
    end
  end

endmodule

// File: rtl/lzs_ctrl.sv
// Sequencer for the layer z-order stack: alloc scans; others plan, shift and commit as needed.
module lzs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          out_free,
  input  lzs_pkg::sts_t sts,
  output logic          in_ready,
  output lzs_pkg::cmd_t cmd
);
  import lzs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = sts.alloc ? S_SCAN : S_PLAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit || sts.scan_end) begin
          state_next = S_RESP;
        end
      end
      S_PLAN: begin
        cmd.plan = 1'b1;
        priority if (sts.need_shift) begin
          state_next = S_SHIFT;
        end else if (sts.need_commit) begin
          state_next = S_COMMIT;
        end else begin
          state_next = S_RESP;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_last) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        cmd.respond = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/lzs_dp.sv
// Datapath for the layer z-order stack: slot flags, height and order memories, top register.
module lzs_dp #(
  parameter int LAYER_COUNT = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lzs_pkg::cmd_t                       cmd,
  input  logic [1:0]                          kind,
  input  logic [lzs_pkg::SLOT_W-1:0]          slot,
  input  logic signed [lzs_pkg::HGT_W-1:0]    requested_height,
  output lzs_pkg::sts_t                       sts,
  output lzs_pkg::status_t                    res_status,
  output logic [lzs_pkg::SLOT_W-1:0]          res_slot,
  output logic signed [lzs_pkg::HGT_W-1:0]    res_height,
  output logic signed [lzs_pkg::HGT_W-1:0]    top_q
);
  import lzs_pkg::*;

  localparam int IDX_W = $clog2(LAYER_COUNT);

  logic [LAYER_COUNT-1:0]    in_use;
  logic signed [HGT_W-1:0]   heights [LAYER_COUNT];
  logic [IDX_W-1:0]          order [LAYER_COUNT];

  kind_t                     kind_q;
  logic [SLOT_W-1:0]         slot_q;
  logic signed [HGT_W-1:0]   req_q;
  logic signed [HGT_W-1:0]   h_rd;
  logic [IDX_W-1:0]          ord_rd;
  logic [IDX_W-1:0]          scan_q;
  logic [IDX_W-1:0]          src_q;
  logic [IDX_W-1:0]          dst_q;
  logic [HGT_W-1:0]          cnt_q;
  logic                      dir_up_q;
  logic                      pend;
  logic signed [HGT_W-1:0]   tgt_q;
  logic                      put_q;
  logic                      show_q;
  logic                      hide_q;

  logic [IDX_W-1:0]          slot_idx;
  logic                      slot_ok;
  logic                      edit;
  logic signed [HGT_W:0]     old_w;
  logic signed [HGT_W:0]     top_w;
  logic signed [HGT_W:0]     lim_w;
  logic signed [HGT_W:0]     req_w;
  logic signed [HGT_W:0]     tgt_w;
  logic                      mv_down;
  logic                      mv_hide;
  logic                      mv_up;
  logic                      mv_show;
  logic signed [HGT_W:0]     cnt_w;
  logic signed [HGT_W:0]     src_w;

  logic                      hw_en;
  logic [IDX_W-1:0]          hw_addr;
  logic signed [HGT_W-1:0]   hw_data;
  logic                      ow_en;
  logic [IDX_W-1:0]          ow_addr;
  logic [IDX_W-1:0]          ow_data;

  assign slot_idx = slot_q[IDX_W-1:0];
  assign slot_ok  = ({1'b0, slot_q} < (SLOT_W+1)'(LAYER_COUNT)) && in_use[slot_idx];
  assign edit     = slot_ok && (kind_q == KIND_SET || kind_q == KIND_FREE);

  always_comb begin
    old_w = {h_rd[HGT_W-1], h_rd};
    top_w = {top_q[HGT_W-1], top_q};
    req_w = {req_q[HGT_W-1], req_q};
    lim_w = (old_w >= 0) ? top_w : top_w + 10'sd1;
    if (kind_q == KIND_SET) begin
      tgt_w = req_w;
      if (tgt_w > lim_w) begin
        tgt_w = lim_w;
      end
      if (tgt_w < -10'sd1) begin
        tgt_w = -10'sd1;
      end
    end else begin
      tgt_w = -10'sd1;
    end
    mv_down = (old_w > tgt_w) && (tgt_w >= 0);
    mv_hide = (old_w > tgt_w) && (tgt_w < 0);
    mv_up   = (old_w < tgt_w) && (old_w >= 0);
    mv_show = (old_w < tgt_w) && (old_w < 0);
    priority if (mv_down) begin
      cnt_w = old_w - tgt_w;
      src_w = old_w - 10'sd1;
    end else if (mv_hide) begin
      cnt_w = top_w - old_w;
      src_w = old_w + 10'sd1;
    end else if (mv_up) begin
      cnt_w = tgt_w - old_w;
      src_w = old_w + 10'sd1;
    end else if (mv_show) begin
      cnt_w = top_w - tgt_w + 10'sd1;
      src_w = top_w;
    end else begin
      cnt_w = '0;
      src_w = '0;
    end
  end

  assign sts.alloc       = (kind_q == KIND_ALLOC);
  assign sts.scan_hit    = !in_use[scan_q];
  assign sts.scan_end    = (scan_q == IDX_W'(LAYER_COUNT - 1));
  assign sts.need_shift  = edit && (cnt_w > 0);
  assign sts.need_commit = edit;
  assign sts.shift_last  = (cnt_q == HGT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
      top_q  <= HGT_NONE;
      pend   <= 1'b0;
    end else begin
      pend <= cmd.shift;
      if (cmd.scan && sts.scan_hit) begin
        in_use[scan_q] <= 1'b1;
      end
      if (cmd.commit) begin
        if (kind_q == KIND_FREE) begin
          in_use[slot_idx] <= 1'b0;
        end
        priority if (show_q) begin
          top_q <= top_q + 9'sd1;
        end else if (hide_q) begin
          top_q <= top_q - 9'sd1;
        end else begin
          top_q <= top_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind_t'(kind);
      slot_q <= slot;
      req_q  <= requested_height;
      scan_q <= '0;
    end
    if (cmd.scan) begin
      res_height <= HGT_NONE;
      if (sts.scan_hit) begin
        res_status <= ST_OK;
        res_slot   <= SLOT_W'(scan_q);
      end else if (sts.scan_end) begin
        res_status <= ST_FULL;
        res_slot   <= '0;
      end else begin
        scan_q <= scan_q + 1'b1;
      end
    end
    if (cmd.plan) begin
      tgt_q    <= tgt_w[HGT_W-1:0];
      cnt_q    <= cnt_w[HGT_W-1:0];
      src_q    <= src_w[IDX_W-1:0];
      dir_up_q <= mv_hide || mv_up;
      put_q    <= mv_down || mv_up || mv_show;
      show_q   <= mv_show;
      hide_q   <= mv_hide;
      res_slot <= slot_q;
      res_status <= ((kind_q == KIND_SET || kind_q == KIND_FREE) && !slot_ok) ?
                    ST_UNUSED : ST_OK;
      if (slot_ok && kind_q == KIND_SET) begin
        res_height <= tgt_w[HGT_W-1:0];
      end else if (slot_ok && kind_q == KIND_PEEK) begin
        res_height <= h_rd;
      end else begin
        res_height <= HGT_NONE;
      end
    end
    if (cmd.shift) begin
      src_q <= dir_up_q ? src_q + 1'b1 : src_q - 1'b1;
      dst_q <= dir_up_q ? src_q - 1'b1 : src_q + 1'b1;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_comb begin
    hw_en   = 1'b0;
    hw_addr = slot_idx;
    hw_data = tgt_q;
    ow_en   = 1'b0;
    ow_addr = dst_q;
    ow_data = ord_rd;
    priority if (cmd.scan) begin
      hw_en   = sts.scan_hit;
      hw_addr = scan_q;
      hw_data = HGT_NONE;
    end else if (pend) begin
      hw_en   = 1'b1;
      hw_addr = ord_rd;
      hw_data = HGT_W'(dst_q);
      ow_en   = 1'b1;
    end else if (cmd.commit) begin
      hw_en   = 1'b1;
      ow_en   = put_q && !tgt_q[HGT_W-1];
      ow_addr = tgt_q[IDX_W-1:0];
      ow_data = slot_idx;
    end else begin
      hw_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hw_en) begin
      heights[hw_addr] <= hw_data;
    end
    h_rd <= heights[slot_idx];
  end

  always_ff @(posedge clk) begin
    if (ow_en) begin
      order[ow_addr] <= ow_data;
    end
    if (cmd.shift) begin
      ord_rd <= order[src_q];
    end
  end

`ifndef SYNTHESIS
  a_top_only_on_commit: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(top_q))
    else $error("top position moved outside commit");
  a_top_range: assert property (@(posedge clk) disable iff (rst)
    (top_q >= HGT_NONE) && (top_q <= 10'(LAYER_COUNT - 1)))
    else $error("top position out of range");
  a_flags_stable: assert property (@(posedge clk) disable iff (rst)
    (!cmd.scan && !cmd.commit) |=> $stable(in_use))
    else $error("slot flags changed without scan or commit");
  a_shift_count: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> (cnt_q != '0))
    else $error("shift with empty count");
`endif

endmodule

// File: test/layer_z_order_stack_core_tb.sv
// Self-checking testbench for the layer z-order stack core.
module layer_z_order_stack_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lzs_pkg::*;

  localparam int NSLOTS      = 256;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_WAIT  = 300;

  typedef struct packed {
    status_t                  st;
    logic [SLOT_W-1:0]        sl;
    logic signed [HGT_W-1:0]  hgt;
    logic signed [HGT_W-1:0]  top;
  } layer_result_t;

  typedef struct packed {
    kind_t                    k;
    logic [SLOT_W-1:0]        s;
    logic signed [HGT_W-1:0]  h;
    logic                     typed;
    status_t                  st;
    logic [SLOT_W-1:0]        rs;
    logic signed [HGT_W-1:0]  rh;
    logic signed [HGT_W-1:0]  rt;
  } stim_row_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                kind = KIND_ALLOC;
  logic [SLOT_W-1:0]         slot = '0;
  logic signed [HGT_W-1:0]   requested_height = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                status;
  logic [SLOT_W-1:0]         result_slot;
  logic signed [HGT_W-1:0]   result_height;
  logic signed [HGT_W-1:0]   top_position;

  bit  in_use_m [NSLOTS];
  int  height_m [NSLOTS];
  int  stack_m  [NSLOTS];
  int  top_m = -1;

  layer_result_t pending_results [$];
  int  err_count  = 0;
  int  words_seen = 0;
  int  cycles     = 0;
  int  send_quiet = 0;
  bit  calm       = 1'b0;
  bit  hold_out   = 1'b0;

  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{KIND_SET,   8'd5,   9'sd3,   1'b1, ST_UNUSED, 8'd5,   HGT_NONE, HGT_NONE},
    '{KIND_FREE,  8'd255, 9'sd0,   1'b1, ST_UNUSED, 8'd255, HGT_NONE, HGT_NONE},
    '{KIND_PEEK,  8'd0,   9'sd0,   1'b1, ST_OK,     8'd0,   HGT_NONE, HGT_NONE},
    '{KIND_ALLOC, 8'd0,   9'sd0,   1'b1, ST_OK,     8'd0,   HGT_NONE, HGT_NONE},
    '{KIND_ALLOC, 8'd77,  9'sd0,   1'b1, ST_OK,     8'd1,   HGT_NONE, HGT_NONE},
    '{KIND_ALLOC, 8'd255, HGT_NONE, 1'b1, ST_OK,    8'd2,   HGT_NONE, HGT_NONE},
    '{KIND_SET,   8'd0,   9'sd255, 1'b1, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_SET,   8'd1,   9'h100,  1'b1, ST_OK,     8'd1,   HGT_NONE, 9'sd0},
    '{KIND_SET,   8'd1,   9'sd0,   1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_SET,   8'd2,   9'sd255, 1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_SET,   8'd0,   9'sd255, 1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_SET,   8'd0,   9'sd0,   1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_SET,   8'd2,   -9'sd2,  1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_PEEK,  8'd2,   9'sd0,   1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_PEEK,  8'd0,   9'sd0,   1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_FREE,  8'd0,   9'sd0,   1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_FREE,  8'd0,   9'sd0,   1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_SET,   8'd255, 9'sd255, 1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_PEEK,  8'd1,   9'sd0,   1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_ALLOC, 8'd0,   9'sd0,   1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_SET,   8'd0,   9'sd1,   1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_SET,   8'd1,   HGT_NONE, 1'b0, ST_OK,    8'd0,   9'sd0,    9'sd0},
    '{KIND_FREE,  8'd1,   9'sd0,   1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_SET,   8'd0,   9'h100,  1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0},
    '{KIND_FREE,  8'd2,   9'sd0,   1'b0, ST_OK,     8'd0,   9'sd0,    9'sd0}
  };

  layer_z_order_stack_core #(.LAYER_COUNT(NSLOTS)) i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .slot             (slot),
    .requested_height (requested_height),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .result_slot      (result_slot),
    .result_height    (result_height),
    .top_position     (top_position)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void place(int pos, int s);
    stack_m[pos] = s;
    height_m[s]  = pos;
  endfunction

  function automatic void restack(int s, int req);
    int was;
    int lim;
    int i;
    was = height_m[s];
    lim = (was >= 0) ? top_m : top_m + 1;
    if (req > lim) req = lim;
    if (req < -1) req = -1;
    height_m[s] = req;
    if (was > req) begin
      if (req >= 0) begin
        for (i = was; i > req; i--) place(i, stack_m[i-1]);
        place(req, s);
      end else begin
        for (i = was; i < top_m; i++) place(i, stack_m[i+1]);
        top_m--;
      end
    end else if (was < req) begin
      if (was >= 0) begin
        for (i = was; i < req; i++) place(i, stack_m[i+1]);
        place(req, s);
      end else begin
        for (i = top_m; i >= req; i--) place(i + 1, stack_m[i]);
        place(req, s);
        top_m++;
      end
    end
  endfunction

  function automatic layer_result_t apply_layer_op(kind_t k, logic [SLOT_W-1:0] s,
                                                   logic signed [HGT_W-1:0] req);
    layer_result_t r;
    int idx;
    bit found;
    idx   = int'(s);
    found = 1'b0;
    r.st  = ST_OK;
    r.sl  = s;
    r.hgt = HGT_NONE;
    case (k)
      KIND_ALLOC: begin
        r.st = ST_FULL;
        r.sl = '0;
        idx  = 0;
        while (!found && idx < NSLOTS) begin
          if (!in_use_m[idx]) begin
            in_use_m[idx] = 1'b1;
            height_m[idx] = -1;
            r.st  = ST_OK;
            r.sl  = SLOT_W'(idx);
            found = 1'b1;
          end
          idx++;
        end
      end
      KIND_SET: begin
        if (!in_use_m[idx]) begin
          r.st = ST_UNUSED;
        end else begin
          restack(idx, int'(req));
          r.hgt = HGT_W'(height_m[idx]);
        end
      end
      KIND_FREE: begin
        if (!in_use_m[idx]) begin
          r.st = ST_UNUSED;
        end else begin
          if (height_m[idx] >= 0) restack(idx, -1);
          in_use_m[idx] = 1'b0;
        end
      end
      default: begin
        if (in_use_m[idx]) r.hgt = HGT_W'(height_m[idx]);
      end
    endcase
    r.top = HGT_W'(top_m);
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_used_slot();
    int n;
    int pick;
    int i;
    n = 0;
    for (i = 0; i < NSLOTS; i++) if (in_use_m[i]) n++;
    if (n == 0) return SLOT_W'($urandom_range(0, NSLOTS - 1));
    pick = $urandom_range(0, n - 1);
    for (i = 0; i < NSLOTS; i++) begin
      if (in_use_m[i]) begin
        if (pick == 0) return SLOT_W'(i);
        pick--;
      end
    end
    return '0;
  endfunction

  function automatic logic signed [HGT_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return HGT_W'(int'($urandom_range(0, top_m + 2)) - 1);
      5:             return HGT_NONE;
      6:             return 9'sd255;
      7:             return HGT_W'(-int'($urandom_range(2, 256)));
      default:       return HGT_W'($urandom_range(0, 511));
    endcase
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d (word %0d)", what, got, want, words_seen);
    err_count++;
  endtask

  task automatic push_word(kind_t k, logic [SLOT_W-1:0] s, logic signed [HGT_W-1:0] h,
                           bit typed, layer_result_t fixed);
    layer_result_t want;
    @(negedge clk);
    if (!calm) begin
      if (send_quiet > 0) begin
        send_quiet--;
      end else if ($urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else if ($urandom_range(0, 24) == 0) begin
        send_quiet = $urandom_range(20, 120);
      end
    end
    in_valid         <= 1'b1;
    kind             <= k;
    slot             <= s;
    requested_height <= h;
    do @(posedge clk); while (!in_ready);
    want = apply_layer_op(k, s, h);
    pending_results.push_back(typed ? fixed : want);
  endtask

  task automatic run_phase(int w_alloc, int w_set, int w_free, int n_words);
    kind_t k;
    logic [SLOT_W-1:0] s;
    int r;
    int n;
    for (n = 0; n < n_words; n++) begin
      r = $urandom_range(0, 99);
      s = SLOT_W'($urandom_range(0, NSLOTS - 1));
      if (r < w_alloc) begin
        k = KIND_ALLOC;
      end else if (r < w_alloc + w_set) begin
        k = KIND_SET;
        r = $urandom_range(0, 9);
        if (r >= 1 && r <= 5 && top_m >= 0) s = SLOT_W'(stack_m[$urandom_range(0, top_m)]);
        else if (r != 0) s = pick_used_slot();
      end else if (r < w_alloc + w_set + w_free) begin
        k = KIND_FREE;
        if ($urandom_range(0, 9) != 0) s = pick_used_slot();
      end else begin
        k = KIND_PEEK;
        if ($urandom_range(0, 1) == 0) s = pick_used_slot();
      end
      push_word(k, s, pick_height(), 1'b0, '0);
    end
  endtask

  initial begin
    int stall;
    int quiet;
    stall = 0;
    quiet = 0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!calm && quiet == 0 && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 19) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (quiet > 0) quiet--;
        else if ($urandom_range(0, 49) == 0) quiet = $urandom_range(20, 200);
      end
    end
  end

  // hold the output long enough for the block to back up into its input
  initial begin
    while (words_seen < 400) @(posedge clk);
    hold_out = 1'b1;
    repeat (700) @(posedge clk);
    hold_out = 1'b0;
  end

  always @(posedge clk) begin
    layer_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected word, slot", int'(result_slot), -1);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) flag_mismatch("status", int'(status), int'(want.st));
        if (result_slot !== want.sl) flag_mismatch("slot", int'(result_slot), int'(want.sl));
        if (result_height !== want.hgt)
          flag_mismatch("height", int'(result_height), int'(want.hgt));
        if (top_position !== want.top)
          flag_mismatch("top", int'(top_position), int'(want.top));
      end
      words_seen++;
    end
  end

  initial begin
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("layer_z_order_stack_core verification failed");
    $finish;
  end

  initial begin
    stim_row_t row;
    int n;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (n = 0; n < 25; n++) begin
      row = DIRECTED_ROWS[n];
      push_word(row.k, row.s, row.h, row.typed, '{row.st, row.rs, row.rh, row.rt});
    end
    run_phase(70, 27, 1, 420);
    run_phase(30, 45, 20, 700);
    run_phase(8, 40, 47, 450);
    calm = 1'b1;
    run_phase(30, 40, 25, 380);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("layer_z_order_stack_core verification clean");
    end else begin
      $display("layer_z_order_stack_core verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lzs_pkg.sv
rtl/lzs_ctrl.sv
rtl/lzs_dp.sv
rtl/layer_z_order_stack_core.sv
test/layer_z_order_stack_core_tb.sv
